/* hdl/bpq_pkg.sv */
// Shared types, constants and command codes of the priority ready-queue scheduler.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
package bpq_pkg;

	localparam int NumTasks  = 64;
	localparam int NumLevels = 256;
	localparam int TaskW     = 6;
	localparam int LinkW     = 7;
	localparam int LevelW    = 8;
	localparam int CountW    = 7;
	localparam int WordW     = 32;
	localparam int NumWords  = NumLevels / WordW;
	localparam int WordIdxW  = 3;
	localparam int BitIdxW   = 5;
	localparam int CntW      = 32;

	// A link of all ones marks the end of a list; any value with the top bit set is not a task.
	localparam logic [LinkW-1:0] NilLink = '1;
	localparam logic [LinkW-1:0] BootId  = 7'd64;

	localparam logic [1:0] KIND_ENQ   = 2'd0;
	localparam logic [1:0] KIND_DEQ   = 2'd1;
	localparam logic [1:0] KIND_SCHED = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	localparam logic CFG_IDLE_TASK = 1'b0;
	localparam logic CFG_IDLE_PRIO = 1'b1;

	localparam logic [4:0] OP_NONE   = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_IGN    = 5'd2;
	localparam logic [4:0] OP_TOPW   = 5'd3;
	localparam logic [4:0] OP_TOPB   = 5'd4;
	localparam logic [4:0] OP_AP_RD  = 5'd5;
	localparam logic [4:0] OP_AP_WR  = 5'd6;
	localparam logic [4:0] OP_UN_RD  = 5'd7;
	localparam logic [4:0] OP_UN_LV  = 5'd8;
	localparam logic [4:0] OP_UN_WR  = 5'd9;
	localparam logic [4:0] OP_HD_RD  = 5'd10;
	localparam logic [4:0] OP_NX     = 5'd11;
	localparam logic [4:0] OP_IDLEL  = 5'd12;
	localparam logic [4:0] OP_TL_RD  = 5'd13;
	localparam logic [4:0] OP_COMMIT = 5'd14;
	localparam logic [4:0] OP_TK_RD  = 5'd15;
	localparam logic [4:0] OP_TK_WR  = 5'd16;
	localparam logic [4:0] OP_OUT    = 5'd17;

	localparam logic [1:0] TS_IN  = 2'd0;
	localparam logic [1:0] TS_CUR = 2'd1;
	localparam logic [1:0] TS_NXT = 2'd2;

	localparam logic LV_PRIO = 1'b0;
	localparam logic LV_READ = 1'b1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TaskW-1:0]  task_id;
		logic [LevelW-1:0] task_priority;
		logic              current_exited;
	} item_t;

	typedef struct packed {
		logic [LinkW-1:0]  chosen_task;
		logic              switched;
		logic              resched_needed;
		logic [LevelW-1:0] top_priority;
		logic              status;
	} result_t;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] tsel;
		logic       lvsel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       exited;
		logic       queued_in;
		logic       same;
		logic       old_task;
		logic       old_queued;
		logic       nxt_task;
		logic       nxt_queued;
	} stat_t;

	typedef struct packed {
		logic [TaskW-1:0]  head;
		logic [TaskW-1:0]  tail;
		logic [CountW-1:0] count;
	} lrec_t;

endpackage

/* hdl/bpq_ctrl.sv */
// Controller of the scheduler: sequences enqueue, unlink, schedule and tick steps.
// Depends on bpq_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
module bpq_ctrl import bpq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t st,
	output cmd_t  cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DEC   = 5'd1;
	localparam logic [4:0] S_AP_RD = 5'd2;
	localparam logic [4:0] S_AP_WR = 5'd3;
	localparam logic [4:0] S_UN_RD = 5'd4;
	localparam logic [4:0] S_UN_LV = 5'd5;
	localparam logic [4:0] S_UN_WR = 5'd6;
	localparam logic [4:0] S_SC_HD = 5'd7;
	localparam logic [4:0] S_SC_NX = 5'd8;
	localparam logic [4:0] S_SC_CK = 5'd9;
	localparam logic [4:0] S_SC_1  = 5'd10;
	localparam logic [4:0] S_SC_2  = 5'd11;
	localparam logic [4:0] S_SC_3  = 5'd12;
	localparam logic [4:0] S_SC_4  = 5'd13;
	localparam logic [4:0] S_SC_5  = 5'd14;
	localparam logic [4:0] S_TK_RD = 5'd15;
	localparam logic [4:0] S_TK_WR = 5'd16;
	localparam logic [4:0] S_TOP_W = 5'd17;
	localparam logic [4:0] S_TOP_B = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	logic [4:0] state_q, state_d;
	logic [4:0] ret_q, ret_d;
	logic [1:0] tsel_q, tsel_d;
	logic       lvsel_q, lvsel_d;
	logic       post_top_q, post_top_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		tsel_d     = tsel_q;
		lvsel_d    = lvsel_q;
		post_top_d = post_top_q;
		cmd.op     = OP_NONE;
		cmd.tsel   = tsel_q;
		cmd.lvsel  = lvsel_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				case (st.kind)
					KIND_ENQ: begin
						if (st.queued_in) begin
							cmd.op  = OP_IGN;
							state_d = S_TOP_W;
						end else begin
							tsel_d  = TS_IN;
							lvsel_d = LV_PRIO;
							ret_d   = S_TOP_W;
							state_d = S_AP_RD;
						end
					end
					KIND_DEQ: begin
						if (!st.queued_in) begin
							cmd.op  = OP_IGN;
							state_d = S_TOP_W;
						end else begin
							tsel_d  = TS_IN;
							ret_d   = S_TOP_W;
							state_d = S_UN_RD;
						end
					end
					KIND_SCHED: begin
						post_top_d = 1'b1;
						state_d    = S_TOP_W;
					end
					default: state_d = S_TK_RD;
				endcase
			end
			S_AP_RD: begin
				cmd.op  = OP_AP_RD;
				state_d = S_AP_WR;
			end
			S_AP_WR: begin
				cmd.op  = OP_AP_WR;
				state_d = ret_q;
			end
			S_UN_RD: begin
				cmd.op  = OP_UN_RD;
				state_d = S_UN_LV;
			end
			S_UN_LV: begin
				cmd.op  = OP_UN_LV;
				state_d = S_UN_WR;
			end
			S_UN_WR: begin
				cmd.op  = OP_UN_WR;
				state_d = ret_q;
			end
			S_SC_HD: begin
				cmd.op  = OP_HD_RD;
				state_d = S_SC_NX;
			end
			S_SC_NX: begin
				cmd.op  = OP_NX;
				state_d = S_SC_CK;
			end
			S_SC_CK: begin
				if (st.same) begin
					state_d = S_TOP_W;
				end else if (st.exited && st.old_task && st.old_queued) begin
					tsel_d  = TS_CUR;
					ret_d   = S_SC_1;
					state_d = S_UN_RD;
				end else begin
					state_d = S_SC_1;
				end
			end
			S_SC_1: begin
				if (st.nxt_task && st.nxt_queued) begin
					tsel_d  = TS_NXT;
					ret_d   = S_SC_2;
					state_d = S_UN_RD;
				end else begin
					state_d = S_SC_2;
				end
			end
			S_SC_2: begin
				cmd.op  = OP_IDLEL;
				state_d = S_SC_3;
			end
			S_SC_3: begin
				cmd.op = OP_TL_RD;
				if (!st.exited && st.old_task && !st.old_queued) begin
					state_d = S_SC_4;
				end else begin
					state_d = S_SC_5;
				end
			end
			S_SC_4: begin
				tsel_d  = TS_CUR;
				lvsel_d = LV_READ;
				ret_d   = S_SC_5;
				state_d = S_AP_RD;
			end
			S_SC_5: begin
				cmd.op  = OP_COMMIT;
				state_d = S_TOP_W;
			end
			S_TK_RD: begin
				cmd.op  = OP_TK_RD;
				state_d = S_TK_WR;
			end
			S_TK_WR: begin
				cmd.op  = OP_TK_WR;
				state_d = S_TOP_W;
			end
			S_TOP_W: begin
				cmd.op  = OP_TOPW;
				state_d = S_TOP_B;
			end
			S_TOP_B: begin
				cmd.op = OP_TOPB;
				if (post_top_q) begin
					post_top_d = 1'b0;
					state_d    = S_SC_HD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.op  = OP_OUT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			tsel_q     <= TS_IN;
			lvsel_q    <= LV_PRIO;
			post_top_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_q      <= ret_d;
			tsel_q     <= tsel_d;
			lvsel_q    <= lvsel_d;
			post_top_q <= post_top_d;
		end
	end

endmodule

/* hdl/bpq_dpath.sv */
// Datapath of the scheduler: level and task memories, bitmap, counters and result register.
// Depends on bpq_pkg; executes one cmd_t operation per cycle from the controller.
`timescale 1ns / 1ps
module bpq_dpath import bpq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	output stat_t   st,
	input  item_t   item,
	input  logic    cfg_we,
	input  logic    cfg_addr,
	input  logic [LevelW-1:0] cfg_data,
	output result_t result,
	output logic    done
);

	lrec_t             lvl_mem [NumLevels];
	logic [LinkW-1:0]  nxt_mem [NumTasks];
	logic [LinkW-1:0]  prv_mem [NumTasks];
	logic [LevelW-1:0] tlv_mem [NumTasks];
	logic [CntW-1:0]   run_mem [NumTasks];

	logic [NumLevels-1:0] bitmap_q;
	logic [NumTasks-1:0]  queued_q;
	logic [NumTasks-1:0]  runv_q;
	logic [TaskW-1:0]     idle_id_q;
	logic [LevelW-1:0]    idle_prio_q;
	item_t                in_q;
	logic [LinkW-1:0]     cur_q, nxt_q;
	logic                 resched_q, switched_q, status_q, found_q, done_q;
	logic [LevelW-1:0]    top_q;
	logic [CntW-1:0]      tick_total_q, switch_total_q;
	result_t              res_q;

	logic [WordIdxW-1:0]  widx_s1;
	logic [WordW-1:0]     word_s1;
	logic                 nz_s1;

	logic [TaskW-1:0]     a_id_q, u_id_q;
	logic [LevelW-1:0]    a_lv_q;
	logic [LinkW-1:0]     un_n_q, un_p_q;
	logic [LevelW-1:0]    tl_rd_q;
	lrec_t                lrec_q;
	logic [CntW-1:0]      run_rd_q;

	logic [TaskW-1:0]     sel_id;
	logic [LevelW-1:0]    sel_lv;
	logic                 ap_empty;
	lrec_t                ap_rec, un_rec;
	logic [CountW-1:0]    un_cnt;

	logic [WordIdxW-1:0]  w_pick;
	logic                 w_nz;
	logic [BitIdxW-1:0]   b_pick;
	logic [LevelW-1:0]    tk_lv;

	// Memory write and read ports, one of each per array per cycle.
	logic                 nm_we, pm_we, tm_we, lm_we, lm_re;
	logic [TaskW-1:0]     nm_wa, pm_wa, tm_wa, tm_ra;
	logic [LinkW-1:0]     nm_wd, pm_wd;
	logic [LevelW-1:0]    tm_wd, lm_wa, lm_ra;
	lrec_t                lm_wd;

	always_comb begin
		case (cmd.tsel)
			TS_CUR:  sel_id = cur_q[TaskW-1:0];
			TS_NXT:  sel_id = nxt_q[TaskW-1:0];
			default: sel_id = in_q.task_id;
		endcase
		sel_lv = (cmd.lvsel == LV_READ) ? tl_rd_q : in_q.task_priority;
	end

	// Highest non-empty bitmap word, then highest bit within it.
	always_comb begin
		w_pick = '0;
		w_nz   = 1'b0;
		for (int w = 0; w < NumWords; w++) begin
			if (|bitmap_q[w*WordW +: WordW]) begin
				w_pick = WordIdxW'(w);
				w_nz   = 1'b1;
			end
		end
		b_pick = '0;
		for (int b = 0; b < WordW; b++) begin
			if (word_s1[b]) b_pick = BitIdxW'(b);
		end
	end

	always_comb begin
		ap_empty = !bitmap_q[a_lv_q];
		if (ap_empty) begin
			ap_rec.head  = a_id_q;
			ap_rec.tail  = a_id_q;
			ap_rec.count = CountW'(1);
		end else begin
			ap_rec.head  = lrec_q.head;
			ap_rec.tail  = a_id_q;
			ap_rec.count = lrec_q.count + CountW'(1);
		end
		un_cnt = bitmap_q[tl_rd_q] ? lrec_q.count : '0;
		if (un_cnt != '0) un_cnt = un_cnt - CountW'(1);
		un_rec.head  = un_p_q[LinkW-1] ? un_n_q[TaskW-1:0] : lrec_q.head;
		un_rec.tail  = un_n_q[LinkW-1] ? un_p_q[TaskW-1:0] : lrec_q.tail;
		un_rec.count = un_cnt;
		tk_lv = cur_q[LinkW-1] ? idle_prio_q : tl_rd_q;
	end

	always_comb begin
		nm_we = 1'b0; nm_wa = sel_id; nm_wd = NilLink;
		pm_we = 1'b0; pm_wa = a_id_q; pm_wd = NilLink;
		tm_we = 1'b0; tm_wa = sel_id; tm_wd = sel_lv;
		lm_we = 1'b0; lm_wa = a_lv_q; lm_wd = ap_rec;
		lm_re = 1'b0; lm_ra = sel_lv;
		tm_ra = sel_id;
		case (cmd.op)
			OP_AP_RD: begin
				nm_we = 1'b1;
				tm_we = 1'b1;
				lm_re = 1'b1;
			end
			OP_AP_WR: begin
				pm_we = 1'b1;
				pm_wd = ap_empty ? NilLink : {1'b0, lrec_q.tail};
				nm_we = !ap_empty;
				nm_wa = lrec_q.tail;
				nm_wd = {1'b0, a_id_q};
				lm_we = 1'b1;
			end
			OP_UN_LV: begin
				lm_re = 1'b1;
				lm_ra = tl_rd_q;
			end
			OP_UN_WR: begin
				nm_we = !un_p_q[LinkW-1];
				nm_wa = un_p_q[TaskW-1:0];
				nm_wd = un_n_q;
				pm_we = !un_n_q[LinkW-1];
				pm_wa = un_n_q[TaskW-1:0];
				pm_wd = un_p_q;
				lm_we = 1'b1;
				lm_wa = tl_rd_q;
				lm_wd = un_rec;
			end
			OP_HD_RD: begin
				lm_re = 1'b1;
				lm_ra = top_q;
			end
			OP_IDLEL: begin
				// The idle task chosen by fallback runs at the idle level.
				tm_we = !nxt_q[LinkW-1] && !found_q;
				tm_wa = nxt_q[TaskW-1:0];
				tm_wd = idle_prio_q;
			end
			OP_TL_RD, OP_TK_RD: tm_ra = cur_q[TaskW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (nm_we) nxt_mem[nm_wa] <= nm_wd;
		if (pm_we) prv_mem[pm_wa] <= pm_wd;
		if (tm_we) tlv_mem[tm_wa] <= tm_wd;
		if (lm_we) lvl_mem[lm_wa] <= lm_wd;
		if (lm_re) lrec_q <= lvl_mem[lm_ra];
		if (cmd.op == OP_UN_RD || cmd.op == OP_TL_RD || cmd.op == OP_TK_RD) begin
			tl_rd_q <= tlv_mem[tm_ra];
		end
		if (cmd.op == OP_UN_RD) begin
			un_n_q <= nxt_mem[sel_id];
			un_p_q <= prv_mem[sel_id];
			u_id_q <= sel_id;
		end
		if (cmd.op == OP_AP_RD) begin
			a_id_q <= sel_id;
			a_lv_q <= sel_lv;
		end
		if (cmd.op == OP_TK_RD) run_rd_q <= run_mem[cur_q[TaskW-1:0]];
		if (cmd.op == OP_TK_WR && !cur_q[LinkW-1]) begin
			run_mem[cur_q[TaskW-1:0]] <=
				(runv_q[cur_q[TaskW-1:0]] ? run_rd_q : '0) + CntW'(1);
		end
		if (cmd.op == OP_LOAD) in_q <= item;
		if (cmd.op == OP_TOPW) begin
			widx_s1 <= w_pick;
			word_s1 <= bitmap_q[w_pick*WordW +: WordW];
			nz_s1   <= w_nz;
		end
		if (cmd.op == OP_NX) nxt_q <= found_q ? {1'b0, lrec_q.head} : {1'b0, idle_id_q};
		if (cmd.op == OP_OUT) res_q <= '{chosen_task: cur_q, switched: switched_q,
			resched_needed: resched_q, top_priority: top_q, status: status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q       <= '0;
			queued_q       <= '0;
			runv_q         <= '0;
			idle_id_q      <= '0;
			idle_prio_q    <= '0;
			cur_q          <= BootId;
			resched_q      <= 1'b0;
			switched_q     <= 1'b0;
			status_q       <= 1'b0;
			found_q        <= 1'b0;
			top_q          <= '0;
			tick_total_q   <= '0;
			switch_total_q <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT);
			if (cfg_we) begin
				if (cfg_addr == CFG_IDLE_TASK) idle_id_q <= cfg_data[TaskW-1:0];
				else idle_prio_q <= cfg_data;
			end
			case (cmd.op)
				OP_LOAD: begin
					switched_q <= 1'b0;
					status_q   <= 1'b0;
				end
				OP_IGN: status_q <= 1'b1;
				OP_TOPB: begin
					found_q <= nz_s1;
					top_q   <= nz_s1 ? {widx_s1, b_pick} : idle_prio_q;
				end
				OP_AP_WR: begin
					bitmap_q[a_lv_q] <= 1'b1;
					queued_q[a_id_q] <= 1'b1;
				end
				OP_UN_WR: begin
					if (un_cnt == '0) bitmap_q[tl_rd_q] <= 1'b0;
					queued_q[u_id_q] <= 1'b0;
				end
				OP_NX: resched_q <= 1'b0;
				OP_COMMIT: begin
					cur_q          <= nxt_q;
					switched_q     <= 1'b1;
					switch_total_q <= switch_total_q + CntW'(1);
				end
				OP_TK_RD: tick_total_q <= tick_total_q + CntW'(1);
				OP_TK_WR: begin
					if (!cur_q[LinkW-1]) runv_q[cur_q[TaskW-1:0]] <= 1'b1;
					if (bitmap_q[tk_lv]) resched_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign st.kind       = in_q.kind;
	assign st.exited     = in_q.current_exited;
	assign st.queued_in  = queued_q[in_q.task_id];
	assign st.same       = (nxt_q == cur_q);
	assign st.old_task   = !cur_q[LinkW-1];
	assign st.old_queued = queued_q[cur_q[TaskW-1:0]];
	assign st.nxt_task   = !nxt_q[LinkW-1];
	assign st.nxt_queued = queued_q[nxt_q[TaskW-1:0]];

	assign result = res_q;
	assign done   = done_q;

endmodule

/* hdl/bitmap_priority_ready_queue_top.sv */
// Priority ready-queue scheduler: 256 levels of linked task lists searched by a level bitmap.
// A new item is taken in the cycle done shows. The order of steps is set by the serial passes over
// the level and task memories, one read and one write port each, and the two-step bitmap search.
// The receiver cannot stall: each result is shown for one cycle on result with done.
// Reset (arst_n low) empties every level, clears the counters and makes the bootstrap context current.
`timescale 1ns / 1ps
module bitmap_priority_ready_queue_top import bpq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output result_t           result,
	output logic              done,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [LevelW-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t st;

	bpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	bpq_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.result   (result),
		.done     (done)
	);

endmodule

/* hdl/bpq_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
// Depends on bpq_pkg for the item and result types.
`timescale 1ns / 1ps
module bpq_checker import bpq_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input result_t result,
	input logic    done
);

	// An accepted item keeps the block busy until its result.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item accepted but block not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("two results for one item");

	// A switch only comes from a schedule item, which never reports ignored.
	a_switch_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.switched |-> !result.status) else $error("switch with ignored status");

endmodule

bind bitmap_priority_ready_queue_top bpq_checker u_bpq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.result (result),
	.done   (done)
);

/* test/tb_bitmap_priority_ready_queue_top.sv */
// Self-checking testbench of the priority ready-queue scheduler top level.
// Needs bpq_pkg and bitmap_priority_ready_queue_top; predicts each result in a class of its own.
`timescale 1ns / 1ps
module tb_bitmap_priority_ready_queue_top;
	import bpq_pkg::*;

	localparam int IdleLimit = 2000;

	class sched_scoreboard;
		logic [LevelW-1:0] idle_level;
		logic [TaskW-1:0]  idle_task;
		bit [255:0]        level_map;
		int unsigned       head[256], tail[256], depth[256];
		int unsigned       nxt[64], prv[64], lvl[64];
		bit                on_queue[64];
		int unsigned       cur;
		bit                resched;
		result_t           pending[$];
		int                mismatches;

		function void reset_state();
			level_map = '0;
			for (int i = 0; i < 256; i++) depth[i] = 0;
			for (int i = 0; i < 64; i++) begin
				on_queue[i] = 0;
				lvl[i] = 0;
			end
			cur = 64;
			resched = 0;
			idle_level = '0;
			idle_task = '0;
			mismatches = 0;
		endfunction

		function int unsigned best_level(output bit found);
			found = 0;
			for (int l = 255; l >= 0; l--) begin
				if (level_map[l]) begin
					found = 1;
					return l;
				end
			end
			return idle_level;
		endfunction

		function void push_tail(int unsigned id, int unsigned l);
			lvl[id] = l;
			nxt[id] = 127;
			if (depth[l] == 0) begin
				head[l] = id;
				prv[id] = 127;
			end else begin
				prv[id] = tail[l];
				nxt[tail[l]] = id;
			end
			tail[l] = id;
			depth[l]++;
			level_map[l] = 1;
			on_queue[id] = 1;
		endfunction

		function void take_out(int unsigned id);
			int unsigned l, p, n;
			l = lvl[id];
			p = prv[id];
			n = nxt[id];
			if (p < 64) nxt[p] = n;
			else head[l] = n;
			if (n < 64) prv[n] = p;
			else tail[l] = p;
			if (depth[l] > 0) depth[l]--;
			if (depth[l] == 0) level_map[l] = 0;
			on_queue[id] = 0;
		endfunction

		function void configure(logic idx, logic [LevelW-1:0] val);
			if (idx == CFG_IDLE_TASK) idle_task = val[TaskW-1:0];
			else idle_level = val;
		endfunction

		function void note_item(item_t it);
			result_t r;
			bit found;
			int unsigned l, old, pick;
			r = '0;
			case (it.kind)
				KIND_ENQ: begin
					if (on_queue[it.task_id]) r.status = 1;
					else push_tail(it.task_id, it.task_priority);
				end
				KIND_DEQ: begin
					if (!on_queue[it.task_id]) r.status = 1;
					else take_out(it.task_id);
				end
				KIND_SCHED: begin
					l = best_level(found);
					old = cur;
					pick = found ? head[l] : idle_task;
					resched = 0;
					if (pick != old) begin
						if (it.current_exited && old < 64 && on_queue[old]) take_out(old);
						if (on_queue[pick]) take_out(pick);
						if (!found) lvl[pick] = idle_level;
						if (!it.current_exited && old < 64 && !on_queue[old])
							push_tail(old, lvl[old]);
						cur = pick;
						r.switched = 1;
					end
				end
				default: begin
					l = (cur < 64) ? lvl[cur] : idle_level;
					if (depth[l] > 0) resched = 1;
				end
			endcase
			r.chosen_task = LinkW'(cur);
			r.resched_needed = resched;
			r.top_priority = LevelW'(best_level(found));
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("result %p with nothing outstanding", got);
				return;
			end
			want = pending.pop_front();
			if (got.chosen_task !== want.chosen_task || got.switched !== want.switched ||
			    got.resched_needed !== want.resched_needed ||
			    got.top_priority !== want.top_priority || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic              clk, arst_n, start, busy, done, cfg_we, cfg_addr;
	item_t             item;
	result_t           result;
	logic [LevelW-1:0] cfg_data;
	sched_scoreboard   board;
	int                send_gap_pct;
	int                quiet_cycles;
	bit                timed_out;

	bitmap_priority_ready_queue_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.result(result), .done(done), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(result);
		if ((start && !busy) || done) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= IdleLimit && !timed_out) begin
			timed_out = 1;
			$display("tb_bitmap_priority_ready_queue_top: errors");
			$finish;
		end
	end

	// Within a run of items, start is lowered only when a gap is wanted, so back-to-back items keep it high.
	task automatic issue(item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(it);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send(logic [1:0] k, int id, int prio, bit ex);
		item_t it;
		it.kind = k;
		it.task_id = TaskW'(id);
		it.task_priority = LevelW'(prio);
		it.current_exited = ex;
		issue(it);
	endtask

	task automatic drain();
		stop_sending();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [LevelW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.configure(idx, val);
	endtask

	// Enqueues most often, half the time over a narrow band of levels, so lists grow and schedules see real heads.
	task automatic random_items(int count, int span);
		item_t it;
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			it = item_t'($urandom);
			if (roll < 40) it.kind = KIND_ENQ;
			else if (roll < 55) it.kind = KIND_DEQ;
			else if (roll < 85) it.kind = KIND_SCHED;
			else it.kind = KIND_TICK;
			if ($urandom_range(3) != 0) it.task_id = TaskW'($urandom_range(span));
			if ($urandom_range(1) == 0) it.task_priority = LevelW'(250 + $urandom_range(5));
			issue(it);
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		timed_out = 0;
		quiet_cycles = 0;
		send_gap_pct = 17;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_IDLE_TASK;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: tick and schedule from bootstrap, extremes of ids and levels, duplicates.
		send(KIND_TICK, 0, 0, 0);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_DEQ, 5, 0, 0);
		send(KIND_ENQ, 63, 255, 0);
		send(KIND_ENQ, 63, 10, 0);
		send(KIND_ENQ, 0, 0, 0);
		send(KIND_ENQ, 1, 255, 0);
		send(KIND_ENQ, 2, 255, 1);
		send(KIND_TICK, 0, 0, 0);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_TICK, 0, 0, 0);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_SCHED, 0, 0, 1);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_DEQ, 63, 0, 0);
		send(KIND_DEQ, 0, 0, 0);
		send(KIND_SCHED, 0, 0, 1);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_DEQ, 2, 0, 0);
		send(KIND_DEQ, 1, 0, 0);
		send(KIND_SCHED, 0, 0, 0);
		drain();

		write_reg(CFG_IDLE_TASK, 8'd63);
		write_reg(CFG_IDLE_PRIO, 8'd255);
		send(KIND_SCHED, 0, 0, 0);
		send(KIND_TICK, 0, 0, 0);
		send(KIND_ENQ, 63, 255, 0);
		send(KIND_TICK, 0, 0, 0);
		random_items(220, 63);
		drain();

		send_gap_pct = 73;
		write_reg(CFG_IDLE_TASK, 8'd0);
		write_reg(CFG_IDLE_PRIO, 8'd0);
		random_items(220, 15);
		drain();

		send_gap_pct = 0;
		write_reg(CFG_IDLE_TASK, LevelW'($urandom_range(63)));
		write_reg(CFG_IDLE_PRIO, LevelW'($urandom_range(255)));
		random_items(290, 31);
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_bitmap_priority_ready_queue_top: clean");
		else
			$display("tb_bitmap_priority_ready_queue_top: errors");
		$finish;
	end

endmodule
